### sv/open_address_hash_table_macros.svh
// Assertion macros used by the checker file
`ifndef OPEN_ADDRESS_HASH_TABLE_MACROS_SVH
`define OPEN_ADDRESS_HASH_TABLE_MACROS_SVH

// Assert a property on the rising edge of clk, off during reset
`define OAH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert a property on the rising edge of clk, also during reset
`define OAH_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/oah_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oah_pkg
// Types and codes for the open-addressing hash table.
// ----------------------------------------------------------------------------
package oah_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_SPARE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        OUT_OK        = 2'd0,
        OUT_DUPLICATE = 2'd1,
        OUT_FULL      = 2'd2,
        OUT_NOT_FOUND = 2'd3
    } outcome_t;

    typedef enum logic [1:0] {
        SLOT_EMPTY    = 2'd0,
        SLOT_OCCUPIED = 2'd1,
        SLOT_DELETED  = 2'd2
    } slot_st_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] lookup_key;
        logic [31:0] payload_word;
    } req_t;

    typedef struct packed {
        logic [1:0] outcome;
        logic [7:0] slot_index;
        logic [8:0] entry_count;
        logic       full_flag;
        logic       empty_flag;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOOK,
        ST_FREE_READ,
        ST_FREE,
        ST_RESP
    } fsm_t;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture request, reset probe to home slot
        logic rd;         // issue read of current slot
        logic adv;        // step to next slot
        logic restart;    // return to home slot, clear probe count
        logic mark_found; // remember current slot as stop slot
        logic wr_ins;     // write insert into current slot
        logic wr_del;     // mark stop slot deleted
        logic set_rsp;    // load response register
        logic [1:0] outc;
        logic zero_slot;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic       slot_empty;
        logic       is_match;
        logic       is_free;
        logic       last_probe;
        logic       tbl_full;
        logic [1:0] op;
    } sts_t;

endpackage

### sv/open_address_hash_table.sv
`timescale 1ns / 1ps
// Each lookup probe passes through ST_READ and ST_LOOK; an insert adds ST_FREE_READ and
// ST_FREE per free-slot probe plus an update step in ST_RESP, and a remove that hits adds that update step.
// Throughput: one request at a time; the next can be taken the cycle after the response
// leaves. The single-port slot memory sets the pace.
// Worst case walks all TABLE_SIZE slots twice. Reset (rst_n) empties the table
// at once through per-slot valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// open_address_hash_table
// Double-hashing open-addressing table: insert, remove and search.
// ----------------------------------------------------------------------------
module open_address_hash_table #(
    parameter int TABLE_SIZE   = 256,
    parameter int KEY_BITS     = 32,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  oah_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output oah_pkg::rsp_t out_data
);
    oah_pkg::cmd_t cmd;
    oah_pkg::sts_t sts;

    oah_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd));

    oah_datapath #(
        .TABLE_SIZE(TABLE_SIZE), .KEY_BITS(KEY_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .req(in_data), .cmd(cmd), .sts(sts), .rsp(out_data));
endmodule

### sv/oah_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oah_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module oah_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one word a cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end
endmodule

### sv/oah_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oah_datapath
// Probe address, slot memories, valid bits, count and response register.
// ----------------------------------------------------------------------------
module oah_datapath #(
    parameter int TABLE_SIZE   = 256,
    parameter int KEY_BITS     = 32,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  oah_pkg::req_t req,
    input  oah_pkg::cmd_t cmd,
    output oah_pkg::sts_t sts,
    output oah_pkg::rsp_t rsp
);
    localparam int AW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(TABLE_SIZE + 1);

    logic [KEY_BITS-1:0]     key_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [1:0]              op_reg;
    logic [AW-1:0]           home_reg, step_reg, addr_reg, stop_reg;
    logic [CW-1:0]           probes_reg, cnt_reg, cnt_next;
    logic [TABLE_SIZE-1:0]   valid_reg;
    logic [1:0]              st_rd;
    logic                    st_vld_reg;
    logic [KEY_BITS-1:0]     key_rd;
    logic [PAYLOAD_BITS-1:0] pay_rd;
    logic [KEY_BITS-1:0]     key_in;
    logic [AW-1:0]           home_c, step_c, q_c, addr_next, stop_c;
    logic [AW:0]             sum_c;
    logic [1:0]              st_cur, st_wdata;
    logic                    st_we;
    oah_pkg::rsp_t           rsp_reg;

    assign key_in = KEY_BITS'(req.lookup_key);

    // Home slot and odd step, modulo table size
    always_comb
    begin
        home_c = AW'(key_in % TABLE_SIZE);
        q_c    = AW'((key_in / TABLE_SIZE) % TABLE_SIZE);
        if (!q_c[0])
        begin
            step_c = AW'((32'(q_c) + 32'd1) % TABLE_SIZE);
        end
        else
        begin
            step_c = q_c;
        end
        if (step_c == '0)
        begin
            step_c = AW'(1);
        end
        sum_c = (AW + 1)'(addr_reg) + (AW + 1)'(step_reg);
        if (sum_c >= (AW + 1)'(TABLE_SIZE))
        begin
            addr_next = AW'(sum_c - (AW + 1)'(TABLE_SIZE));
        end
        else
        begin
            addr_next = AW'(sum_c);
        end
        // An exhausted walk stops one step past the last slot read
        stop_c = cmd.adv ? addr_next : addr_reg;
        if (cmd.wr_ins)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (cmd.wr_del)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    // Hold request and walk the probe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probes_reg <= '0;
            cnt_reg    <= '0;
            valid_reg  <= '0;
            st_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load || cmd.restart)
            begin
                probes_reg <= '0;
            end
            else if (cmd.adv)
            begin
                probes_reg <= probes_reg + CW'(1);
            end
            if (cmd.rd)
            begin
                st_vld_reg <= valid_reg[addr_reg];
            end
            if (cmd.wr_ins)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
            if (cmd.wr_del)
            begin
                valid_reg[stop_reg] <= 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= key_in;
            pay_reg  <= PAYLOAD_BITS'(req.payload_word);
            op_reg   <= req.opcode;
            home_reg <= home_c;
            step_reg <= step_c;
            addr_reg <= home_c;
        end
        else if (cmd.restart)
        begin
            addr_reg <= home_reg;
        end
        else if (cmd.adv)
        begin
            addr_reg <= addr_next;
        end
        if (cmd.mark_found)
        begin
            stop_reg <= stop_c;
        end
    end

    // Slot memories; state written on insert and delete
    assign st_we    = cmd.wr_ins || cmd.wr_del;
    assign st_wdata = cmd.wr_ins ? 2'(oah_pkg::SLOT_OCCUPIED) : 2'(oah_pkg::SLOT_DELETED);

    oah_ram #(.WIDTH(2), .DEPTH(TABLE_SIZE)) u_state (
        .clk(clk), .we(st_we), .re(cmd.rd),
        .addr(cmd.wr_del ? stop_reg : addr_reg), .wdata(st_wdata), .rdata(st_rd));
    oah_ram #(.WIDTH(KEY_BITS), .DEPTH(TABLE_SIZE)) u_key (
        .clk(clk), .we(cmd.wr_ins), .re(cmd.rd),
        .addr(addr_reg), .wdata(key_reg), .rdata(key_rd));
    oah_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(TABLE_SIZE)) u_pay (
        .clk(clk), .we(cmd.wr_ins), .re(1'b0),
        .addr(addr_reg), .wdata(pay_reg), .rdata(pay_rd));

    // Status of the slot just read; unwritten slots read as empty
    always_comb
    begin
        st_cur         = st_vld_reg ? st_rd : 2'(oah_pkg::SLOT_EMPTY);
        sts.slot_empty = (st_cur == 2'(oah_pkg::SLOT_EMPTY));
        sts.is_match   = (st_cur == 2'(oah_pkg::SLOT_OCCUPIED)) && (key_rd == key_reg);
        sts.is_free    = (st_cur != 2'(oah_pkg::SLOT_OCCUPIED));
        sts.last_probe = (probes_reg == CW'(TABLE_SIZE - 1));
        sts.tbl_full   = (cnt_reg >= CW'(TABLE_SIZE));
        sts.op         = op_reg;
    end

    // Response register; takes the slot and count as they stand after this cycle
    always_ff @(posedge clk)
    begin
        if (cmd.set_rsp)
        begin
            rsp_reg.outcome     <= cmd.outc;
            rsp_reg.slot_index  <= cmd.zero_slot ? 8'd0 :
                                   8'(cmd.mark_found ? stop_c : stop_reg);
            rsp_reg.entry_count <= 9'(cnt_next);
            rsp_reg.full_flag   <= (cnt_next == CW'(TABLE_SIZE));
            rsp_reg.empty_flag  <= (cnt_next == '0);
        end
    end
    assign rsp = rsp_reg;
endmodule

### sv/oah_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oah_ctrl
// Sequencer: lookup walk, free-slot walk, update and response.
// ----------------------------------------------------------------------------
module oah_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  oah_pkg::sts_t sts,
    output oah_pkg::cmd_t cmd
);
    oah_pkg::fsm_t state_reg, state_next;
    logic          found_reg, found_next;
    logic          upd_reg, upd_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        found_next = found_reg;
        upd_next   = 1'b0;
        case (state_reg)
            oah_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = oah_pkg::ST_READ;
                end
            end
            oah_pkg::ST_READ:
            begin
                state_next = oah_pkg::ST_LOOK;
            end
            oah_pkg::ST_LOOK:
            begin
                if (sts.is_match)
                begin
                    found_next = 1'b1;
                    state_next = oah_pkg::ST_RESP;
                end
                else if (sts.slot_empty || sts.last_probe)
                begin
                    found_next = 1'b0;
                    if (sts.op == 2'(oah_pkg::OP_INSERT) && !sts.tbl_full)
                    begin
                        state_next = oah_pkg::ST_FREE_READ;
                    end
                    else
                    begin
                        state_next = oah_pkg::ST_RESP;
                    end
                end
                else
                begin
                    state_next = oah_pkg::ST_READ;
                end
            end
            oah_pkg::ST_FREE_READ:
            begin
                state_next = oah_pkg::ST_FREE;
            end
            oah_pkg::ST_FREE:
            begin
                if (sts.is_free)
                begin
                    found_next = 1'b1;
                    upd_next   = 1'b1;
                    state_next = oah_pkg::ST_RESP;
                end
                else if (sts.last_probe)
                begin
                    state_next = oah_pkg::ST_RESP;
                end
                else
                begin
                    state_next = oah_pkg::ST_FREE_READ;
                end
            end
            oah_pkg::ST_RESP:
            begin
                // Hold through the update cycle; leave only once the response is taken
                if (out_ready && !upd_reg)
                begin
                    state_next = oah_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = oah_pkg::ST_IDLE;
            end
        endcase
        if (state_reg == oah_pkg::ST_LOOK && sts.is_match && sts.op == 2'(oah_pkg::OP_REMOVE))
        begin
            upd_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oah_pkg::ST_IDLE;
            found_reg <= 1'b0;
            upd_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
            upd_reg   <= upd_next;
        end
    end

    // Outputs
    always_comb
    begin
        cmd        = '0;
        in_ready   = (state_reg == oah_pkg::ST_IDLE);
        out_valid  = 1'b0;
        case (state_reg)
            oah_pkg::ST_IDLE:
            begin
                cmd.load = in_valid;
            end
            oah_pkg::ST_READ, oah_pkg::ST_FREE_READ:
            begin
                cmd.rd = 1'b1;
            end
            oah_pkg::ST_LOOK:
            begin
                if (sts.is_match || sts.slot_empty || sts.last_probe)
                begin
                    cmd.mark_found = 1'b1;
                    cmd.adv        = sts.last_probe && !sts.is_match && !sts.slot_empty;
                    cmd.set_rsp    = 1'b1;
                    if (sts.is_match)
                    begin
                        cmd.outc = (sts.op == 2'(oah_pkg::OP_INSERT)) ?
                                   2'(oah_pkg::OUT_DUPLICATE) : 2'(oah_pkg::OUT_OK);
                    end
                    else if (sts.op == 2'(oah_pkg::OP_INSERT))
                    begin
                        cmd.outc      = 2'(oah_pkg::OUT_FULL);
                        cmd.zero_slot = 1'b1;
                        cmd.restart   = !sts.tbl_full;
                        cmd.adv       = 1'b0;
                    end
                    else
                    begin
                        cmd.outc = 2'(oah_pkg::OUT_NOT_FOUND);
                    end
                end
                else
                begin
                    cmd.adv = 1'b1;
                end
            end
            oah_pkg::ST_FREE:
            begin
                if (sts.is_free)
                begin
                    cmd.mark_found = 1'b1;
                    cmd.wr_ins     = 1'b1;
                end
                else if (sts.last_probe)
                begin
                    cmd.set_rsp   = 1'b1;
                    cmd.outc      = 2'(oah_pkg::OUT_FULL);
                    cmd.zero_slot = 1'b1;
                end
                else
                begin
                    cmd.adv = 1'b1;
                end
            end
            oah_pkg::ST_RESP:
            begin
                out_valid = !upd_reg;
                if (upd_reg)
                begin
                    cmd.set_rsp = 1'b1;
                    cmd.outc    = 2'(oah_pkg::OUT_OK);
                    cmd.wr_del  = (sts.op == 2'(oah_pkg::OP_REMOVE)) && found_reg;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end
endmodule

### sv/oah_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oah_checker
// Port-level checks on the hash table, bound to the top level.
// ----------------------------------------------------------------------------
`include "open_address_hash_table_macros.svh"
module oah_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input oah_pkg::rsp_t out_data
);
    `OAH_ASSERT(a_one_at_a_time, !(in_ready && out_valid), "request taken while response pending")
    `OAH_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "response dropped")
    `OAH_ASSERT(a_flags, out_valid |-> !(out_data.full_flag && out_data.empty_flag), "full and empty")
    `OAH_ASSERT_ALWAYS(a_reset, !rst_n |-> !out_valid, "response during reset")
endmodule

bind open_address_hash_table oah_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data));
